### hw/rtl/assert_macros.svh
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition: label");

`endif

### hw/rtl/qpid_pkg.sv
// shared constants and types of the two-axis pid mixer
// no dependencies
package qpid_pkg;

  localparam int unsigned IntegWidthDefault = 32;
  localparam int unsigned AngleW            = 16;
  localparam int unsigned GainW             = 16;
  localparam int unsigned MotorW            = 16;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned FracBits          = 20;
  localparam int unsigned NumMotors         = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP_ROLL       = 3'd0,
    REG_KI_ROLL       = 3'd1,
    REG_KD_ROLL       = 3'd2,
    REG_KP_PITCH      = 3'd3,
    REG_KI_PITCH      = 3'd4,
    REG_KD_PITCH      = 3'd5,
    REG_MOTOR_FLOOR   = 3'd6,
    REG_MOTOR_CEILING = 3'd7
  } qpid_reg_e;

  // pipeline advance strobes for the multiply and sum stages
  typedef struct packed {
    logic load_s2;
    logic load_s3;
  } qpid_adv_t;

endpackage

### hw/rtl/quad_two_axis_pid_mixer_core.sv
// top level of the two-axis pid controller with quad x-frame mixer
// depends on qpid_pkg, qpid_err_front, qpid_axis_mac and qpid_mixer
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one control tick per
//   transaction: measured and target roll and pitch (signed q8.8) and throttle
// - output channel (out_valid_o / out_stall_i) returns the four clamped motor
//   drives, one transaction per input transaction, in order
// - config channel (cfg_valid_i / cfg_ready_o) writes gains and motor limits by
//   register index; it is always ready and must only be used while idle
// - pipeline: a result passes four register stages (error and integrator,
//   gain products, term sum, mix and clamp into the output register)
// - throughput: one transaction per cycle unless the output stalls; the
//   integrator and last-error state update in the same cycle the input is taken
// - stall: a stalled output holds its value; empty stages still fill, and once
//   all four stages are full the input stall follows the output stall
// - reset: pipeline empty, state zero, gains and limits at their defaults
module quad_two_axis_pid_mixer_core import qpid_pkg::*; #(
  parameter int unsigned INTEGRATOR_WIDTH = IntegWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [AngleW-1:0] measured_roll_i,
  input  logic signed [AngleW-1:0] measured_pitch_i,
  input  logic signed [AngleW-1:0] target_roll_i,
  input  logic signed [AngleW-1:0] target_pitch_i,
  input  logic        [MotorW-1:0] throttle_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [MotorW-1:0] motor_one_o,
  output logic        [MotorW-1:0] motor_two_o,
  output logic        [MotorW-1:0] motor_three_o,
  output logic        [MotorW-1:0] motor_four_o,
  // config channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic       [CfgIdxW-1:0] cfg_index_i,
  input  logic        [GainW-1:0]  cfg_data_i
);

  localparam int unsigned AccW = INTEGRATOR_WIDTH + 18;

  // config registers
  logic [GainW-1:0]  kp_roll_q, ki_roll_q, kd_roll_q;
  logic [GainW-1:0]  kp_pitch_q, ki_pitch_q, kd_pitch_q;
  logic [MotorW-1:0] floor_q, ceiling_q;
  qpid_reg_e         cfg_reg;

  // pipeline control
  logic      v1_q, v2_q, v3_q, out_valid_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  logic      accept;
  logic      load_out;
  qpid_adv_t adv;

  // datapath
  logic signed [AngleW-1:0]           err_roll, err_pitch;
  logic signed [AngleW:0]             diff_roll, diff_pitch;
  logic signed [INTEGRATOR_WIDTH-1:0] sum_roll, sum_pitch;
  logic signed [AccW-1:0]             acc_roll, acc_pitch;
  logic [MotorW-1:0]                  thr1_q, thr2_q, thr3_q;
  logic [NumMotors-1:0][MotorW-1:0]   motor_d, motor_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = qpid_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_roll_q  <= 16'd4096;
      ki_roll_q  <= 16'd410;
      kd_roll_q  <= 16'd41;
      kp_pitch_q <= '0;
      ki_pitch_q <= '0;
      kd_pitch_q <= '0;
      floor_q    <= '0;
      ceiling_q  <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg)
        REG_KP_ROLL:       kp_roll_q  <= cfg_data_i;
        REG_KI_ROLL:       ki_roll_q  <= cfg_data_i;
        REG_KD_ROLL:       kd_roll_q  <= cfg_data_i;
        REG_KP_PITCH:      kp_pitch_q <= cfg_data_i;
        REG_KI_PITCH:      ki_pitch_q <= cfg_data_i;
        REG_KD_PITCH:      kd_pitch_q <= cfg_data_i;
        REG_MOTOR_FLOOR:   floor_q    <= cfg_data_i;
        REG_MOTOR_CEILING: ceiling_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- pipeline control
  // a stage may load when it is empty or its contents move on this cycle
  assign rdy4 = !out_valid_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign accept      = in_valid_i && rdy1;
  assign adv.load_s2 = v1_q && rdy2;
  assign adv.load_s3 = v2_q && rdy3;
  assign load_out    = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        out_valid_q <= v3_q;
      end
    end
  end

  // throttle rides alongside the axis pipelines
  always_ff @(posedge clk_i) begin
    if (accept) begin
      thr1_q <= throttle_i;
    end
    if (adv.load_s2) begin
      thr2_q <= thr1_q;
    end
    if (adv.load_s3) begin
      thr3_q <= thr2_q;
    end
  end

  // ---------------------------------------------------------- axis datapaths
  qpid_err_front #(.IntegW(INTEGRATOR_WIDTH)) u_front_roll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .target_i   (target_roll_i),
    .measured_i (measured_roll_i),
    .err_o      (err_roll),
    .diff_o     (diff_roll),
    .sum_o      (sum_roll)
  );

  qpid_err_front #(.IntegW(INTEGRATOR_WIDTH)) u_front_pitch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .target_i   (target_pitch_i),
    .measured_i (measured_pitch_i),
    .err_o      (err_pitch),
    .diff_o     (diff_pitch),
    .sum_o      (sum_pitch)
  );

  qpid_axis_mac #(.IntegW(INTEGRATOR_WIDTH)) u_mac_roll (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .kp_i   (kp_roll_q),
    .ki_i   (ki_roll_q),
    .kd_i   (kd_roll_q),
    .err_i  (err_roll),
    .diff_i (diff_roll),
    .sum_i  (sum_roll),
    .acc_o  (acc_roll)
  );

  qpid_axis_mac #(.IntegW(INTEGRATOR_WIDTH)) u_mac_pitch (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .kp_i   (kp_pitch_q),
    .ki_i   (ki_pitch_q),
    .kd_i   (kd_pitch_q),
    .err_i  (err_pitch),
    .diff_i (diff_pitch),
    .sum_i  (sum_pitch),
    .acc_o  (acc_pitch)
  );

  // ------------------------------------------------------------ mix, output
  qpid_mixer #(.IntegW(INTEGRATOR_WIDTH)) u_mixer (
    .acc_roll_i  (acc_roll),
    .acc_pitch_i (acc_pitch),
    .throttle_i  (thr3_q),
    .floor_i     (floor_q),
    .ceiling_i   (ceiling_q),
    .motor_o     (motor_d)
  );

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      motor_q <= motor_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_one_o   = motor_q[0];
  assign motor_two_o   = motor_q[1];
  assign motor_three_o = motor_q[2];
  assign motor_four_o  = motor_q[3];

endmodule

### hw/rtl/qpid_err_front.sv
// per-axis error stage: saturated error, derivative difference and integrator state
// depends on qpid_pkg
module qpid_err_front import qpid_pkg::*; #(
  parameter int unsigned IntegW = IntegWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic signed [AngleW-1:0] target_i,
  input  logic signed [AngleW-1:0] measured_i,
  output logic signed [AngleW-1:0] err_o,
  output logic signed [AngleW:0]   diff_o,
  output logic signed [IntegW-1:0] sum_o
);

  logic signed [AngleW:0]   raw_err;
  logic signed [AngleW-1:0] err;
  logic signed [AngleW:0]   diff;
  logic signed [IntegW:0]   sum_ext;
  logic signed [IntegW-1:0] sum_d, sum_q;
  logic signed [AngleW-1:0] prev_q;
  logic signed [AngleW-1:0] err_q;
  logic signed [AngleW:0]   diff_q;
  logic signed [IntegW-1:0] sum_old_q;

  assign raw_err = {target_i[AngleW-1], target_i} - {measured_i[AngleW-1], measured_i};

  always_comb begin
    if (raw_err[AngleW] != raw_err[AngleW-1]) begin
      err = raw_err[AngleW] ? {1'b1, {(AngleW-1){1'b0}}} : {1'b0, {(AngleW-1){1'b1}}};
    end else begin
      err = raw_err[AngleW-1:0];
    end
  end

  assign diff    = {err[AngleW-1], err} - {prev_q[AngleW-1], prev_q};
  assign sum_ext = {sum_q[IntegW-1], sum_q} + {{(IntegW+1-AngleW){err[AngleW-1]}}, err};

  // saturating integrator
  always_comb begin
    if (sum_ext[IntegW] != sum_ext[IntegW-1]) begin
      sum_d = sum_ext[IntegW] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      sum_d = sum_ext[IntegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else if (accept_i) begin
      prev_q <= err;
      sum_q  <= sum_d;
    end
  end

  // sum before this tick's error is the one the integral term uses
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      err_q     <= err;
      diff_q    <= diff;
      sum_old_q <= sum_q;
    end
  end

  assign err_o  = err_q;
  assign diff_o = diff_q;
  assign sum_o  = sum_old_q;

endmodule

### hw/rtl/qpid_axis_mac.sv
// per-axis gain products and term sum, two register stages
// depends on qpid_pkg
module qpid_axis_mac import qpid_pkg::*; #(
  parameter int unsigned IntegW = IntegWidthDefault,
  localparam int unsigned AccW  = IntegW + 18
) (
  input  logic                     clk_i,
  input  qpid_adv_t                adv_i,
  input  logic        [GainW-1:0]  kp_i,
  input  logic        [GainW-1:0]  ki_i,
  input  logic        [GainW-1:0]  kd_i,
  input  logic signed [AngleW-1:0] err_i,
  input  logic signed [AngleW:0]   diff_i,
  input  logic signed [IntegW-1:0] sum_i,
  output logic signed [AccW-1:0]   acc_o
);

  localparam int unsigned PW = GainW + 1 + AngleW;
  localparam int unsigned DW = GainW + 1 + AngleW + 1;
  localparam int unsigned IW = GainW + 1 + IntegW;

  logic signed [PW-1:0]   p_q;
  logic signed [DW-1:0]   d_q;
  logic signed [IW-1:0]   i_q;
  logic signed [AccW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.load_s2) begin
      p_q <= $signed({1'b0, kp_i}) * err_i;
      d_q <= $signed({1'b0, kd_i}) * diff_i;
      i_q <= $signed({1'b0, ki_i}) * sum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.load_s3) begin
      acc_q <= {{(AccW-PW){p_q[PW-1]}}, p_q}
             + {{(AccW-DW){d_q[DW-1]}}, d_q}
             + {{(AccW-IW){i_q[IW-1]}}, i_q};
    end
  end

  assign acc_o = acc_q;

endmodule

### hw/rtl/qpid_mixer.sv
// truncation of both corrections, x-frame mix and motor clamp
// depends on qpid_pkg
module qpid_mixer import qpid_pkg::*; #(
  parameter int unsigned IntegW = IntegWidthDefault,
  localparam int unsigned AccW  = IntegW + 18
) (
  input  logic signed [AccW-1:0]                acc_roll_i,
  input  logic signed [AccW-1:0]                acc_pitch_i,
  input  logic        [MotorW-1:0]              throttle_i,
  input  logic        [MotorW-1:0]              floor_i,
  input  logic        [MotorW-1:0]              ceiling_i,
  output logic        [NumMotors-1:0][MotorW-1:0] motor_o
);

  localparam int unsigned UW   = AccW - FracBits;
  localparam int unsigned MixW = UW + 2;

  logic                   fix_roll, fix_pitch;
  logic signed [UW-1:0]   ur, up;
  logic signed [MixW-1:0] thr_ext, ur_ext, up_ext, ceil_ext, floor_ext;
  logic signed [MixW-1:0] mix [NumMotors];

  // round toward zero: bump negative values that lost fraction bits
  assign fix_roll  = acc_roll_i[AccW-1] & (|acc_roll_i[FracBits-1:0]);
  assign fix_pitch = acc_pitch_i[AccW-1] & (|acc_pitch_i[FracBits-1:0]);

  assign ur = $signed(acc_roll_i[AccW-1:FracBits]) + $signed({{(UW-1){1'b0}}, fix_roll});
  assign up = $signed(acc_pitch_i[AccW-1:FracBits]) + $signed({{(UW-1){1'b0}}, fix_pitch});

  assign thr_ext   = $signed({{(MixW-MotorW){1'b0}}, throttle_i});
  assign ceil_ext  = $signed({{(MixW-MotorW){1'b0}}, ceiling_i});
  assign floor_ext = $signed({{(MixW-MotorW){1'b0}}, floor_i});
  assign ur_ext    = {{2{ur[UW-1]}}, ur};
  assign up_ext    = {{2{up[UW-1]}}, up};

  assign mix[0] = thr_ext + ur_ext + up_ext;
  assign mix[1] = thr_ext + ur_ext - up_ext;
  assign mix[2] = thr_ext - ur_ext + up_ext;
  assign mix[3] = thr_ext - ur_ext - up_ext;

  // ceiling wins over floor
  always_comb begin
    for (int k = 0; k < NumMotors; k++) begin
      if (mix[k] > ceil_ext) begin
        motor_o[k] = ceiling_i;
      end else if (mix[k] < floor_ext) begin
        motor_o[k] = floor_i;
      end else begin
        motor_o[k] = mix[k][MotorW-1:0];
      end
    end
  end

endmodule

### hw/rtl/qpid_checker.sv
// port-level checks of the pid mixer core, bound to the top level
// depends on assert_macros.svh and quad_two_axis_pid_mixer_core
`include "assert_macros.svh"

module qpid_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_i,
  input logic out_valid_i,
  input logic out_stall_i
);

  logic in_taken;

  assign in_taken = in_valid_i && !in_stall_i;

  // a stalled result is not withdrawn
  `ASSERT_PROP(a_out_held, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)

  // without output back pressure the input never stalls
  `ASSERT_NEVER(a_no_idle_stall, clk_i, rst_ni, !out_stall_i && in_stall_i)

  // a transaction taken while the output flows freely is offered at the output
  `ASSERT_PROP(a_latency, clk_i, rst_ni, in_taken ##1 !out_stall_i [*3] |=> out_valid_i)

endmodule

bind quad_two_axis_pid_mixer_core qpid_checker u_qpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i)
);
